// ===== src/sst_pkg.sv =====
// Shared definitions for the sorted set table: default sizes, opcode
// codes and the width of the reported entry count.
// No dependencies.
package sst_pkg;

  // Default table size and key width
  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_KEY_BITS = 16;

  // Width of the entry count reported with each result
  localparam int COUNT_OUT_BITS = 11;

  // Command opcodes; code 3 is unused and changes nothing
  localparam logic [1:0] OP_MEMBER = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

endpackage

// ===== src/sst_mem.sv =====
// Key store of the sorted set table: one write port and one read port,
// read data registered.
// Depends on nothing but its parameters.
module sst_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sst_ctrl.sv =====
// Sequencer of the sorted set table: walks the key store once per command,
// searching and then shifting entries up (insert) or down (delete).
// Depends on sst_pkg; drives the ports of sst_mem.
module sst_ctrl import sst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS,
  parameter int AW       = 10,
  parameter int CW       = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [KEY_BITS-1:0]       key,
  // result side
  output logic                      done,
  output logic                      success,
  output logic                      full_res,
  output logic [COUNT_OUT_BITS-1:0] entry_count,
  // key store
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [KEY_BITS-1:0]       rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [KEY_BITS-1:0]       wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SEARCH   = 5'b00010,
    ST_INS_MOVE = 5'b00100,
    ST_INS_TAIL = 5'b01000,
    ST_DEL_MOVE = 5'b10000
  } state_t;

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t              state, state_next;
  logic [1:0]          op, op_next;
  logic [KEY_BITS-1:0] key_r, key_next;
  logic [KEY_BITS-1:0] carry, carry_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       nxt_addr, nxt_addr_next;
  logic [CW-1:0]       rd_idx;
  logic                rv;
  logic                fin, ok, full;
  logic                last, hit, stop, is_full;

  assign busy    = (state != ST_IDLE);
  assign last    = (CW'(rd_idx + 1'b1) == count);
  assign hit     = (rd_data == key_r);
  assign stop    = (rd_data >= key_r);
  assign is_full = (count >= CAP);

  // Next-state and store access
  always_comb begin
    state_next    = state;
    op_next       = op;
    key_next      = key_r;
    carry_next    = carry;
    count_next    = count;
    nxt_addr_next = nxt_addr;
    rd_en         = 1'b0;
    rd_addr       = nxt_addr[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = rd_idx[AW-1:0];
    wr_data       = carry;
    fin           = 1'b0;
    ok            = 1'b0;
    full          = 1'b0;

    // keep the read stream going one entry per cycle while scanning
    if ((state == ST_SEARCH || state == ST_INS_MOVE || state == ST_DEL_MOVE) &&
        (nxt_addr < count)) begin
      rd_en         = 1'b1;
      nxt_addr_next = CW'(nxt_addr + 1'b1);
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_next    = opcode;
          key_next   = key;
          state_next = ST_SEARCH;
          if (count != '0) begin
            rd_en         = 1'b1;
            rd_addr       = '0;
            nxt_addr_next = CW'(1);
          end
        end
      end

      ST_SEARCH: begin
        if (op != OP_MEMBER && op != OP_INSERT && op != OP_DELETE) begin
          fin = 1'b1;
        end else if (count == '0 || (rv && !stop && last)) begin
          // key belongs after every held entry
          fin = 1'b1;
          if (op == OP_INSERT) begin
            if (is_full) begin
              full = 1'b1;
            end else begin
              wr_en      = 1'b1;
              wr_addr    = count[AW-1:0];
              wr_data    = key_r;
              count_next = CW'(count + 1'b1);
              ok         = 1'b1;
            end
          end
        end else if (rv && stop) begin
          case (op)
            OP_MEMBER: begin
              fin = 1'b1;
              ok  = hit;
            end
            OP_INSERT: begin
              if (hit) begin
                fin = 1'b1;
              end else if (is_full) begin
                fin  = 1'b1;
                full = 1'b1;
              end else begin
                wr_en      = 1'b1;
                wr_data    = key_r;
                carry_next = rd_data;
                state_next = last ? ST_INS_TAIL : ST_INS_MOVE;
              end
            end
            default: begin
              if (!hit) begin
                fin = 1'b1;
              end else if (last) begin
                fin        = 1'b1;
                ok         = 1'b1;
                count_next = CW'(count - 1'b1);
              end else begin
                state_next = ST_DEL_MOVE;
              end
            end
          endcase
        end
      end

      // entry j takes the key displaced from j-1
      ST_INS_MOVE: begin
        wr_en      = 1'b1;
        carry_next = rd_data;
        if (last) begin
          state_next = ST_INS_TAIL;
        end
      end

      ST_INS_TAIL: begin
        wr_en      = 1'b1;
        wr_addr    = count[AW-1:0];
        count_next = CW'(count + 1'b1);
        fin        = 1'b1;
        ok         = 1'b1;
      end

      // entry j moves down to j-1
      ST_DEL_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = AW'(rd_idx - 1'b1);
        wr_data = rd_data;
        if (last) begin
          count_next = CW'(count - 1'b1);
          fin        = 1'b1;
          ok         = 1'b1;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rv    <= rd_en;
      done  <= fin;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    key_r    <= key_next;
    carry    <= carry_next;
    nxt_addr <= nxt_addr_next;
    rd_idx   <= CW'(rd_addr);
    if (fin) begin
      success     <= ok;
      full_res    <= full;
      entry_count <= COUNT_OUT_BITS'(count_next);
    end
  end

endmodule

// ===== src/sorted_set_table.sv =====
// Sorted set table: a set of distinct keys held in ascending order in one
// single-port-read, single-port-write memory. A command transfer happens
// when start is high and busy is low; the result is shown for exactly one
// cycle with done high and cannot be stalled. A command on an empty table
// or with an unused opcode ends soonest; otherwise the block streams the
// memory from entry 0 through one read port, one entry per
// cycle, stopping a query at the first entry not below the key and running
// an insert or delete through the end of the table while it shifts entries.
// busy drops in the cycle the result is shown, so the next command may be
// transferred while done is high. No clearing pass follows reset.
// Depends on sst_pkg, sst_mem and sst_ctrl.
module sorted_set_table import sst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [KEY_BITS-1:0]       key,
  output logic                      done,
  output logic                      success,
  output logic                      full_res,
  output logic [COUNT_OUT_BITS-1:0] entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  sst_ctrl #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .key         (key),
    .done        (done),
    .success     (success),
    .full_res    (full_res),
    .entry_count (entry_count),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  sst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_BITS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // The shift walk never reads the entry it writes in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  // A result always comes with the block ready for the next command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  // A transferred command keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("command transfer did not start a walk");

  // A refused insert never also reports success
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(success && full_res))
    else $error("success and full both set");

endmodule
